[hdl/assert_macros.svh]
// ============================================================================
// Assertion macros
// Shared wrappers for concurrent assertions. They are empty in synthesis.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property holds at every clock edge outside reset.
`define DRC_ASSERT(label, clk_sig, rstn_sig, prop) \
  label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) \
    else $error("dirty range coalescer: assertion failed");
// The consequent holds in the cycle after the antecedent.
`define DRC_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
    else $error("dirty range coalescer: assertion failed");
`else
`define DRC_ASSERT(label, clk_sig, rstn_sig, prop)
`define DRC_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons)
`endif
`endif

[hdl/drc_pkg.sv]
// ============================================================================
// Dirty range coalescer package
// Field widths, word types, register map and a helper function.
// ============================================================================
package drc_pkg;

  // Field widths.
  localparam int ADDR_BITS  = 40;
  localparam int END_BITS   = ADDR_BITS + 1;
  localparam int LEN_BITS   = 32;
  localparam int CNT_BITS   = 33;
  localparam int SHIFT_BITS = 5;

  // Default number of table entries.
  localparam int TABLE_DEPTH_DEF = 16;

  // Configuration port: 64-bit data, registers at 8-byte steps.
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 5;

  typedef enum logic [1:0] {
    REG_REGION_SIZE     = 2'd0,
    REG_FLUSH_THRESHOLD = 2'd1,
    REG_PAGE_SHIFT      = 2'd2
  } reg_idx_t;

  // Register reset values.
  localparam logic [END_BITS-1:0]   REGION_SIZE_RST     = END_BITS'(1) << ADDR_BITS;
  localparam logic [CNT_BITS-1:0]   FLUSH_THRESHOLD_RST = CNT_BITS'(1048576);
  localparam logic [SHIFT_BITS-1:0] PAGE_SHIFT_RST      = SHIFT_BITS'(12);

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_OK     = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] offset;
    logic [LEN_BITS-1:0]  length;
  } in_word_t;

  typedef struct packed {
    kind_t                kind;
    logic [ADDR_BITS-1:0] range_start;
    logic [END_BITS-1:0]  range_end;
    logic                 last;
  } out_word_t;

  // One stored dirty range.
  typedef struct packed {
    logic [ADDR_BITS-1:0] range_start;
    logic [END_BITS-1:0]  range_end;
  } drc_entry_t;

  // Configuration values handed from the register file to the engine.
  typedef struct packed {
    logic [END_BITS-1:0]   region_size;
    logic [CNT_BITS-1:0]   flush_threshold;
    logic [SHIFT_BITS-1:0] page_shift;
  } drc_cfg_t;

  // Clear the low page_shift bits of a start offset.
  function automatic logic [ADDR_BITS-1:0] align_down(input logic [ADDR_BITS-1:0] a,
                                                      input logic [SHIFT_BITS-1:0] sh);
    logic [ADDR_BITS-1:0] mask;
    mask = (ADDR_BITS'(1) << sh) - ADDR_BITS'(1);
    return a & ~mask;
  endfunction

endpackage

[hdl/drc_cfg_regs.sv]
// ============================================================================
// Dirty range coalescer configuration registers
// APB-style register file holding region size, flush threshold and page shift.
// ============================================================================
module drc_cfg_regs
  import drc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output drc_cfg_t              cfg
);

  drc_cfg_t cfg_r;
  reg_idx_t reg_sel;
  logic     wr_en;

  // Registers sit at 8-byte steps, so the index is the upper address bits.
  assign reg_sel = reg_idx_t'(paddr[4:3]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.region_size     <= REGION_SIZE_RST;
      cfg_r.flush_threshold <= FLUSH_THRESHOLD_RST;
      cfg_r.page_shift      <= PAGE_SHIFT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_REGION_SIZE:     cfg_r.region_size     <= pwdata[END_BITS-1:0];
        REG_FLUSH_THRESHOLD: cfg_r.flush_threshold <= pwdata[CNT_BITS-1:0];
        REG_PAGE_SHIFT:      cfg_r.page_shift      <= pwdata[SHIFT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_sel)
      REG_REGION_SIZE:     prdata = APB_DATA_W'(cfg_r.region_size);
      REG_FLUSH_THRESHOLD: prdata = APB_DATA_W'(cfg_r.flush_threshold);
      REG_PAGE_SHIFT:      prdata = APB_DATA_W'(cfg_r.page_shift);
      default:             prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

[hdl/dirty_range_coalescer.sv]
// ============================================================================
// Dirty range coalescer
// Merges write ranges into a small table of dirty ranges and emits them as
// flush ranges with page-aligned starts on table overflow or a byte threshold.
// ============================================================================
//
//   channel  | ports                                      | moves
//   ---------+--------------------------------------------+---------------------
//   input    | in_valid, in_stall, in_data                | one write word
//   result   | out_valid, out_stall, out_data             | one result word
//   config   | psel, penable, pwrite, paddr, pwdata, ...  | 64-bit register
//
// One word is handled at a time. A rejected write goes from the check state back
// to idle; an accepted write is checked, scanned against the stored ranges, merged
// or appended and decided, and a flush emits the stored ranges one after another.
// The scan reads one table entry per cycle from the single range memory.
// Reset is synchronous and clears the control state; the table needs no clear.
// A stalled result holds in the output register while the next word is taken.
//
`include "assert_macros.svh"

module dirty_range_coalescer
  import drc_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_CHECK     = 7'b0000010,
    ST_SCAN      = 7'b0000100,
    ST_APPEND    = 7'b0001000,
    ST_DECIDE    = 7'b0010000,
    ST_FLUSH     = 7'b0100000,
    ST_FLUSH_NEW = 7'b1000000
  } state_t;

  drc_cfg_t cfg;

  state_t               state_r, state_nxt;
  logic [ADDR_BITS-1:0] s_r, s_nxt;
  logic [END_BITS-1:0]  e_r, e_nxt;
  logic [LEN_BITS-1:0]  len_r, len_nxt;
  logic [CNT_BITS-1:0]  bytes_r, bytes_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic                 full_r, full_nxt;
  logic                 out_valid_r;
  out_word_t            out_data_r;

  // Range memory: one write port, one registered read port.
  drc_entry_t           mem [TABLE_DEPTH];
  drc_entry_t           mem_rdata_r;
  logic                 mem_we, mem_re;
  logic [IDX_W-1:0]     mem_waddr, mem_raddr;
  drc_entry_t           mem_wdata;

  logic                 push;
  out_word_t            push_word;
  logic                 slot_free;
  logic [CNT_W-1:0]     idx_inc;
  logic                 last_entry;
  logic [CNT_BITS:0]    bytes_sum;
  logic [CNT_BITS-1:0]  bytes_sat;
  logic                 hit_start, hit_end;

  drc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Shared helpers for the state machine.
  assign slot_free  = !out_valid_r || !out_stall;
  assign idx_inc    = idx_r + CNT_W'(1);
  assign last_entry = (idx_inc == count_r);
  assign bytes_sum  = {1'b0, bytes_r} + (CNT_BITS + 1)'(len_r);
  assign bytes_sat  = bytes_sum[CNT_BITS] ? '1 : bytes_sum[CNT_BITS-1:0];

  // The new start lies in the stored range, or else the new end does.
  assign hit_start = (s_r >= mem_rdata_r.range_start) &&
                     ({1'b0, s_r} <= mem_rdata_r.range_end);
  assign hit_end   = (e_r <= mem_rdata_r.range_end) &&
                     (e_r >= {1'b0, mem_rdata_r.range_start});

  // Sequencer: check, scan and merge or append, then emit the results.
  always_comb begin
    state_nxt = state_r;
    s_nxt     = s_r;
    e_nxt     = e_r;
    len_nxt   = len_r;
    bytes_nxt = bytes_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    full_nxt  = full_r;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    push      = 1'b0;
    push_word = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          s_nxt     = in_data.offset;
          len_nxt   = in_data.length;
          e_nxt     = {1'b0, in_data.offset} + END_BITS'(in_data.length);
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (e_r >= cfg.region_size) begin
          if (slot_free) begin
            push           = 1'b1;
            push_word.kind = KIND_REJECT;
            push_word.last = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else begin
          bytes_nxt = bytes_sat;
          idx_nxt   = '0;
          if (count_r != '0) begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_APPEND;
          end
        end
      end
      ST_SCAN: begin
        // The entry at idx_r is in the read register this cycle.
        if (hit_start) begin
          mem_we                = 1'b1;
          mem_waddr             = idx_r[IDX_W-1:0];
          mem_wdata.range_start = mem_rdata_r.range_start;
          mem_wdata.range_end   = (e_r > mem_rdata_r.range_end) ? e_r
                                                                : mem_rdata_r.range_end;
          state_nxt             = ST_DECIDE;
        end else if (hit_end) begin
          mem_we                = 1'b1;
          mem_waddr             = idx_r[IDX_W-1:0];
          mem_wdata.range_start = (s_r < mem_rdata_r.range_start) ? s_r
                                                                  : mem_rdata_r.range_start;
          mem_wdata.range_end   = mem_rdata_r.range_end;
          state_nxt             = ST_DECIDE;
        end else if (idx_inc < count_r) begin
          idx_nxt   = idx_inc;
          mem_re    = 1'b1;
          mem_raddr = idx_inc[IDX_W-1:0];
        end else begin
          state_nxt = ST_APPEND;
        end
      end
      ST_APPEND: begin
        if (count_r < DEPTH_C) begin
          mem_we                = 1'b1;
          mem_waddr             = count_r[IDX_W-1:0];
          mem_wdata.range_start = s_r;
          mem_wdata.range_end   = e_r;
          count_nxt             = count_r + CNT_W'(1);
        end else begin
          full_nxt = 1'b1;
        end
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        // Any table write finished at the last edge, so reads see it.
        if (!full_r && (bytes_r < cfg.flush_threshold)) begin
          if (slot_free) begin
            push           = 1'b1;
            push_word.kind = KIND_OK;
            push_word.last = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else begin
          idx_nxt   = '0;
          mem_re    = 1'b1;
          mem_raddr = '0;
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          push                  = 1'b1;
          push_word.kind        = KIND_FLUSH;
          push_word.range_start = align_down(mem_rdata_r.range_start, cfg.page_shift);
          push_word.range_end   = mem_rdata_r.range_end;
          push_word.last        = last_entry && !full_r;
          if (last_entry) begin
            if (full_r) begin
              state_nxt = ST_FLUSH_NEW;
            end else begin
              count_nxt = '0;
              bytes_nxt = '0;
              state_nxt = ST_IDLE;
            end
          end else begin
            idx_nxt   = idx_inc;
            mem_re    = 1'b1;
            mem_raddr = idx_inc[IDX_W-1:0];
          end
        end
      end
      ST_FLUSH_NEW: begin
        // The range that found no place goes out last.
        if (slot_free) begin
          push                  = 1'b1;
          push_word.kind        = KIND_FLUSH;
          push_word.range_start = align_down(s_r, cfg.page_shift);
          push_word.range_end   = e_r;
          push_word.last        = 1'b1;
          count_nxt             = '0;
          bytes_nxt             = '0;
          full_nxt              = 1'b0;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bytes_r <= '0;
      count_r <= '0;
      idx_r   <= '0;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bytes_r <= bytes_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      full_r  <= full_nxt;
    end
  end

  // Word registers of the current write.
  always_ff @(posedge clk) begin
    s_r   <= s_nxt;
    e_r   <= e_nxt;
    len_r <= len_nxt;
  end

  // Range memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  // Output register decouples the result side from the engine.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data_r <= push_word;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the table bookkeeping and the sequencer.
  `DRC_ASSERT(a_count_bound, clk, rst_n, count_r <= DEPTH_C)
  `DRC_ASSERT(a_full_only_when_full, clk, rst_n, !full_r || (count_r == DEPTH_C))
  `DRC_ASSERT(a_flush_idx, clk, rst_n, (state_r != ST_FLUSH) || (idx_r < count_r))
  `DRC_ASSERT_NEXT(a_last_to_idle, clk, rst_n, push && push_word.last, state_r == ST_IDLE)
  `DRC_ASSERT_NEXT(a_flush_clears, clk, rst_n,
    push && push_word.last && (push_word.kind == KIND_FLUSH),
    (count_r == '0) && (bytes_r == '0) && !full_r)

endmodule

[tb/dirty_range_coalescer_tb.sv]
// ============================================================================
// Dirty range coalescer testbench
// Sends write words through the input channel and checks every result word
// against a predictor of the range table, the byte counter and the flushes.
// A short directed table covers the extremes, the merge cases, a full table
// and the special register settings. Random phases follow with bursts of
// idling on both channels and one long hold on the result side.
// ============================================================================
`timescale 1ns / 100ps

module dirty_range_coalescer_tb;
  import drc_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 60;
  localparam int RND_PER_PHASE = 48;

  localparam logic [ADDR_BITS-1:0] MAX_OFF      = '1;
  localparam logic [LEN_BITS-1:0]  MAX_LEN      = '1;
  localparam logic [ADDR_BITS-1:0] CLUSTER_BASE = 40'h1_0000;

  // One row of the directed table. Rows marked typed carry their result.
  typedef struct {
    int                   cfg_sel;
    logic [ADDR_BITS-1:0] offset;
    logic [LEN_BITS-1:0]  length;
    bit                   typed;
    kind_t                kind;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Predictor state: dirty range table, byte counter and register copies.
  logic [ADDR_BITS-1:0]  tbl_start [TABLE_DEPTH_DEF];
  logic [END_BITS-1:0]   tbl_end [TABLE_DEPTH_DEF];
  int                    tbl_count = 0;
  logic [CNT_BITS-1:0]   dirty_bytes = '0;
  logic [END_BITS-1:0]   cfg_region = REGION_SIZE_RST;
  logic [CNT_BITS-1:0]   cfg_thresh = FLUSH_THRESHOLD_RST;
  logic [SHIFT_BITS-1:0] cfg_shift = PAGE_SHIFT_RST;

  out_word_t write_results [$];
  out_word_t due_results [$];

  int cycles = 0;
  int err_count = 0;
  bit sender_gaps = 1'b1;
  bit receiver_gaps = 1'b1;
  bit hold_go = 1'b0;

  // Register settings of the directed part: reset values, empty region,
  // zero threshold without alignment, and the widest values.
  drc_cfg_t dir_cfgs [4] = '{
    '{REGION_SIZE_RST, FLUSH_THRESHOLD_RST, PAGE_SHIFT_RST},
    '{41'h0, FLUSH_THRESHOLD_RST, PAGE_SHIFT_RST},
    '{REGION_SIZE_RST, 33'h0, 5'd0},
    '{41'h1FF_FFFF_FFFF, 33'h1_FFFF_FFFF, 5'd31}
  };

  dir_row_t dir_rows [28] = '{
    // Extremes right after reset, including the rejected ones.
    '{0, 40'h0, 32'h0, 1'b1, KIND_OK},
    '{0, MAX_OFF, 32'h0, 1'b1, KIND_OK},
    '{0, MAX_OFF, 32'h1, 1'b1, KIND_REJECT},
    '{0, MAX_OFF, MAX_LEN, 1'b1, KIND_REJECT},
    // New entry, raised end, lowered start, and a covering range appended.
    '{0, 40'h1000, 32'h100, 1'b0, KIND_OK},
    '{0, 40'h1080, 32'h100, 1'b0, KIND_OK},
    '{0, 40'h0F00, 32'h200, 1'b0, KIND_OK},
    '{0, 40'h0E00, 32'h1000, 1'b0, KIND_OK},
    // Disjoint ranges fill the table; the last one overflows it.
    '{0, 40'h1_0000, 32'h10, 1'b0, KIND_OK},
    '{0, 40'h2_0000, 32'h10, 1'b0, KIND_OK},
    '{0, 40'h3_0000, 32'h10, 1'b0, KIND_OK},
    '{0, 40'h4_0000, 32'h10, 1'b0, KIND_OK},
    '{0, 40'h5_0000, 32'h10, 1'b0, KIND_OK},
    '{0, 40'h6_0000, 32'h10, 1'b0, KIND_OK},
    '{0, 40'h7_0000, 32'h10, 1'b0, KIND_OK},
    '{0, 40'h8_0000, 32'h10, 1'b0, KIND_OK},
    '{0, 40'h9_0000, 32'h10, 1'b0, KIND_OK},
    '{0, 40'hA_0000, 32'h10, 1'b0, KIND_OK},
    '{0, 40'hB_0000, 32'h10, 1'b0, KIND_OK},
    '{0, 40'hC_0000, 32'h10, 1'b0, KIND_OK},
    '{0, 40'hD_0000, 32'h10, 1'b0, KIND_OK},
    // An empty region rejects everything.
    '{1, 40'h0, 32'h0, 1'b1, KIND_REJECT},
    '{1, MAX_OFF, MAX_LEN, 1'b1, KIND_REJECT},
    // A zero threshold flushes on every accepted write.
    '{2, 40'h123, 32'h10, 1'b0, KIND_OK},
    '{2, 40'h5, 32'h0, 1'b0, KIND_OK},
    // The counter saturates on the third write and forces a flush.
    '{3, MAX_OFF, MAX_LEN, 1'b0, KIND_OK},
    '{3, 40'h7FFF_FFFF, MAX_LEN, 1'b0, KIND_OK},
    '{3, 40'h8000_0000, MAX_LEN, 1'b0, KIND_OK}
  };

  dirty_range_coalescer i_dut (
    .clk,
    .rst_n,
    .in_valid,
    .in_stall,
    .in_data,
    .out_valid,
    .out_stall,
    .out_data,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  // Clock, 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic flag_error(input string what);
    err_count++;
    if (err_count <= 100) begin
      $display("mismatch at cycle %0d: %s", cycles, what);
    end
  endtask

  function automatic logic [ADDR_BITS-1:0] page_floor(input logic [ADDR_BITS-1:0] a);
    return a & ({ADDR_BITS{1'b1}} << cfg_shift);
  endfunction

  function automatic void add_result(input kind_t k, input logic [ADDR_BITS-1:0] s,
                                     input logic [END_BITS-1:0] e, input logic l);
    out_word_t r;
    r.kind        = k;
    r.range_start = s;
    r.range_end   = e;
    r.last        = l;
    write_results.push_back(r);
  endfunction

  // Applies one write to the predicted table and lists the result words.
  function automatic void coalesce_write(input in_word_t w);
    logic [END_BITS-1:0] e;
    logic [CNT_BITS:0]   sum;
    bit                  placed;
    bit                  full;
    write_results.delete();
    e = END_BITS'(w.offset) + END_BITS'(w.length);
    if (e >= cfg_region) begin
      add_result(KIND_REJECT, '0, '0, 1'b1);
      return;
    end
    // The counter saturates instead of wrapping.
    sum = {1'b0, dirty_bytes} + (CNT_BITS + 1)'(w.length);
    dirty_bytes = sum[CNT_BITS] ? '1 : sum[CNT_BITS-1:0];
    placed = 1'b0;
    for (int i = 0; i < tbl_count && !placed; i++) begin
      if (w.offset >= tbl_start[i] && END_BITS'(w.offset) <= tbl_end[i]) begin
        if (e > tbl_end[i]) tbl_end[i] = e;
        placed = 1'b1;
      end else if (e <= tbl_end[i] && e >= END_BITS'(tbl_start[i])) begin
        if (w.offset < tbl_start[i]) tbl_start[i] = w.offset;
        placed = 1'b1;
      end
    end
    full = 1'b0;
    if (!placed) begin
      if (tbl_count >= TABLE_DEPTH_DEF) begin
        full = 1'b1;
      end else begin
        tbl_start[tbl_count] = w.offset;
        tbl_end[tbl_count]   = e;
        tbl_count++;
      end
    end
    if (!full && dirty_bytes < cfg_thresh) begin
      add_result(KIND_OK, '0, '0, 1'b1);
      return;
    end
    // Flush: every stored range, then the range that found no place.
    for (int i = 0; i < tbl_count; i++) begin
      add_result(KIND_FLUSH, page_floor(tbl_start[i]), tbl_end[i],
                 !full && i == tbl_count - 1);
    end
    if (full) add_result(KIND_FLUSH, page_floor(w.offset), e, 1'b1);
    tbl_count   = 0;
    dirty_bytes = '0;
  endfunction

  // Random write: mostly overlapping writes in one cluster, then disjoint
  // pages, writes near the region end, and fully random words.
  function automatic in_word_t rand_write();
    in_word_t    w;
    int unsigned pick;
    logic [63:0] r;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      w.offset = CLUSTER_BASE + ADDR_BITS'($urandom_range(0, 'h3fff));
      w.length = LEN_BITS'($urandom_range(0, 'h7ff));
    end else if (pick < 82) begin
      w.offset = ADDR_BITS'($urandom_range(2, 60)) << 16;
      w.length = LEN_BITS'($urandom_range(1, 'h3ff));
    end else if (pick < 92) begin
      w.offset = ADDR_BITS'(cfg_region - END_BITS'($urandom_range(1, 'h1000)));
      w.length = LEN_BITS'($urandom_range(0, 'h2000));
    end else begin
      r = {$urandom(), $urandom()};
      w.offset = r[ADDR_BITS-1:0];
      w.length = LEN_BITS'($urandom());
    end
    return w;
  endfunction

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 3'b000});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_REGION_SIZE:     cfg_region = value[END_BITS-1:0];
      REG_FLUSH_THRESHOLD: cfg_thresh = value[CNT_BITS-1:0];
      REG_PAGE_SHIFT:      cfg_shift  = value[SHIFT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input drc_cfg_t c);
    write_reg(REG_REGION_SIZE, APB_DATA_W'(c.region_size));
    write_reg(REG_FLUSH_THRESHOLD, APB_DATA_W'(c.flush_threshold));
    write_reg(REG_PAGE_SHIFT, APB_DATA_W'(c.page_shift));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Holds the input idle until every predicted result word has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  // Offers one write word, possibly after a gap, and records its results.
  task automatic offer_word(input in_word_t w, input bit typed, input kind_t kind);
    out_word_t fixed;
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    coalesce_write(w);
    if (typed) begin
      fixed      = '0;
      fixed.kind = kind;
      fixed.last = 1'b1;
      due_results.push_back(fixed);
    end else begin
      foreach (write_results[j]) due_results.push_back(write_results[j]);
    end
  endtask

  // Result side stalls: one long hold on request, otherwise short bursts.
  initial begin : result_stall
    bit hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Each accepted result word is checked against the oldest prediction.
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (due_results.size() == 0) begin
        flag_error($sformatf("result word %h with none predicted", out_data));
      end else begin
        want = due_results.pop_front();
        if (out_data.kind !== want.kind)
          flag_error($sformatf("kind %0d, predicted %0d", out_data.kind, want.kind));
        if (out_data.range_start !== want.range_start)
          flag_error($sformatf("range_start %h, predicted %h",
                               out_data.range_start, want.range_start));
        if (out_data.range_end !== want.range_end)
          flag_error($sformatf("range_end %h, predicted %h",
                               out_data.range_end, want.range_end));
        if (out_data.last !== want.last)
          flag_error($sformatf("last %b, predicted %b", out_data.last, want.last));
      end
    end
  end

  // Main sequence: reset, directed table, random phases, final check.
  initial begin : stimulus
    drc_cfg_t rnd_cfgs [4];
    in_word_t w;
    int       cur_cfg;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table; the register setting changes only when the block is idle.
    cur_cfg = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_sel != cur_cfg) begin
        drain_results();
        cur_cfg = dir_rows[i].cfg_sel;
        load_config(dir_cfgs[cur_cfg]);
      end
      w.offset = dir_rows[i].offset;
      w.length = dir_rows[i].length;
      offer_word(w, dir_rows[i].typed, dir_rows[i].kind);
    end

    // Random phases under different settings; the last one runs without gaps.
    rnd_cfgs[0] = '{REGION_SIZE_RST, 33'h6000, 5'd12};
    rnd_cfgs[1] = '{41'h40_0000, 33'h2_0000, 5'd9};
    rnd_cfgs[2] = '{REGION_SIZE_RST, 33'h1_0000_0000, 5'd16};
    rnd_cfgs[3] = '{41'h1FF_FFFF_FFFF, 33'h3000, 5'd12};
    rnd_cfgs[3].page_shift = SHIFT_BITS'($urandom_range(9, 16));
    for (int p = 0; p < 4; p++) begin
      drain_results();
      load_config(rnd_cfgs[p]);
      if (p == 0) hold_go = 1'b1;
      if (p == 3) begin
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
      end
      for (int n = 0; n < RND_PER_PHASE; n++) begin
        offer_word(rand_write(), 1'b0, KIND_OK);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/drc_pkg.sv
hdl/drc_cfg_regs.sv
hdl/dirty_range_coalescer.sv
tb/dirty_range_coalescer_tb.sv
